@@ hw/rtl/nciw_pkg.sv @@
package nciw_pkg;

  typedef enum logic [1:0] {
    OP_ROW_START = 2'd0,
    OP_COL_ENTRY = 2'd1,
    OP_MARK      = 2'd2,
    OP_QUERY     = 2'd3
  } op_t;

  localparam logic CFG_ROW_OFFSET = 1'b0;
  localparam logic CFG_COL_OFFSET = 1'b1;

  localparam int unsigned OFS_W = 30;
  localparam int unsigned IDX_W = 13;
  localparam int unsigned VAL_W = 14;
  localparam int unsigned GLB_W = 31;
  localparam int unsigned WGT_W = 17;
  localparam logic [WGT_W-1:0] WEIGHT_ONE = 17'd65536;

  // Q1.16 reciprocal rounded to nearest, ties up: (2*65536 + n) / (2*n), n = 1..64
  function automatic logic [WGT_W-1:0] recip_q16(input logic [6:0] n);
    logic [WGT_W-1:0] r;
    r = WEIGHT_ONE;
    case (n)
      7'd1: r = 17'd65536;  7'd2: r = 17'd32768;  7'd3: r = 17'd21845;
      7'd4: r = 17'd16384;  7'd5: r = 17'd13107;  7'd6: r = 17'd10923;
      7'd7: r = 17'd9362;   7'd8: r = 17'd8192;   7'd9: r = 17'd7282;
      7'd10: r = 17'd6554;  7'd11: r = 17'd5958;  7'd12: r = 17'd5461;
      7'd13: r = 17'd5041;  7'd14: r = 17'd4681;  7'd15: r = 17'd4369;
      7'd16: r = 17'd4096;  7'd17: r = 17'd3855;  7'd18: r = 17'd3641;
      7'd19: r = 17'd3449;  7'd20: r = 17'd3277;  7'd21: r = 17'd3121;
      7'd22: r = 17'd2979;  7'd23: r = 17'd2849;  7'd24: r = 17'd2731;
      7'd25: r = 17'd2621;  7'd26: r = 17'd2521;  7'd27: r = 17'd2427;
      7'd28: r = 17'd2341;  7'd29: r = 17'd2260;  7'd30: r = 17'd2185;
      7'd31: r = 17'd2114;  7'd32: r = 17'd2048;  7'd33: r = 17'd1986;
      7'd34: r = 17'd1928;  7'd35: r = 17'd1872;  7'd36: r = 17'd1820;
      7'd37: r = 17'd1771;  7'd38: r = 17'd1725;  7'd39: r = 17'd1680;
      7'd40: r = 17'd1638;  7'd41: r = 17'd1598;  7'd42: r = 17'd1560;
      7'd43: r = 17'd1524;  7'd44: r = 17'd1489;  7'd45: r = 17'd1456;
      7'd46: r = 17'd1425;  7'd47: r = 17'd1394;  7'd48: r = 17'd1365;
      7'd49: r = 17'd1337;  7'd50: r = 17'd1311;  7'd51: r = 17'd1285;
      7'd52: r = 17'd1260;  7'd53: r = 17'd1237;  7'd54: r = 17'd1214;
      7'd55: r = 17'd1192;  7'd56: r = 17'd1170;  7'd57: r = 17'd1150;
      7'd58: r = 17'd1130;  7'd59: r = 17'd1111;  7'd60: r = 17'd1092;
      7'd61: r = 17'd1074;  7'd62: r = 17'd1057;  7'd63: r = 17'd1040;
      7'd64: r = 17'd1024;
      default: r = WEIGHT_ONE;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/nciw_recip.sv @@
// Restoring divider: weight = (2*65536 + n) / (2*n), one quotient bit per cycle.
module nciw_recip #(
  parameter int unsigned CNT_W = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [CNT_W-1:0]           count,
  output logic                       done,
  output logic [nciw_pkg::WGT_W-1:0] quotient
);
  import nciw_pkg::*;

  localparam int unsigned NUM_W = CNT_W + 19;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [CNT_W+1:0]  den_r, den_nxt;
  logic [CNT_W+2:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W+2:0]  trial;

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[CNT_W+1:0], num_r[NUM_W-1]};
    if (start) begin
      num_nxt  = NUM_W'(18'd131072) + NUM_W'(count);
      den_nxt  = {1'b0, count, 1'b0};
      rem_nxt  = '0;
      step_nxt = STEP_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt    = trial - {1'b0, den_r};
        num_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = WGT_W'(num_r);

endmodule

@@ hw/rtl/nearest_coarse_interpolation_weights.sv @@
// Each load and each out-of-range query yields one result beat via S_QRD and S_OUT; a coarse-node
// query goes through S_QRD, S_QCHK and S_OUT. A fine-node query clears the visited map, then per
// level runs the coarse scan over the frontier nodes and the edge pass over their neighbors,
// then a serial division and one result beat per coarse node found, at most MAX_HITS, or one
// empty beat if none is found; beats are held under output stall. One item is in flight at a time.
// After reset a clearing pass over all MAX_NODES entries zeroes the coarse table before the first item is accepted.
module nearest_coarse_interpolation_weights #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 8192,
  parameter int unsigned MAX_HITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [nciw_pkg::OFS_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [nciw_pkg::IDX_W-1:0]  in_index,
  input  logic [nciw_pkg::VAL_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nciw_pkg::GLB_W-1:0]  out_row_index,
  output logic [nciw_pkg::GLB_W-1:0]  out_col_index,
  output logic [nciw_pkg::WGT_W-1:0]  out_weight,
  output logic                        out_has_entry,
  output logic                        out_last,
  output logic                        out_truncated
);
  import nciw_pkg::*;

  localparam int unsigned NW   = $clog2(MAX_NODES);
  localparam int unsigned RW   = $clog2(MAX_NODES + 1);
  localparam int unsigned EW   = $clog2(MAX_EDGES);
  localparam int unsigned PW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned HW   = $clog2(MAX_HITS);
  localparam int unsigned CW   = NW + 1;
  localparam int unsigned FW   = NW + 1;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_QRD    = 14'b00000000000100,
    S_QCHK   = 14'b00000000001000,
    S_VCLR   = 14'b00000000010000,
    S_LVL    = 14'b00000000100000,
    S_NODE   = 14'b00000001000000,
    S_RS     = 14'b00000010000000,
    S_NBRD   = 14'b00000100000000,
    S_NBCHK  = 14'b00001000000000,
    S_DIV    = 14'b00010000000000,
    S_EMIT   = 14'b00100000000000,
    S_EMWAIT = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  // memories
  logic [VAL_W-1:0] rs_mem [0:MAX_NODES];
  logic [VAL_W-1:0] nb_mem [0:MAX_EDGES-1];
  logic [IDX_W:0]   co_mem [0:MAX_NODES-1];  // {flag, ordinal}
  logic             vis_mem [0:MAX_NODES-1];
  logic [NW-1:0]    fr_mem [0:1][0:MAX_NODES-1];
  logic [NW-1:0]    fl_mem [0:MAX_HITS-1];

  state_t state_r, state_nxt;
  logic [OFS_W-1:0] row_ofs_r, col_ofs_r;
  logic [1:0]       op_r;
  logic [VAL_W-1:0] val_r;
  logic [NW-1:0]    clr_r;
  logic [NW-1:0]    node_r;
  logic             fsel_r;
  logic [FW-1:0]    ncur_r, nnext_r, fi_r;
  logic [CW-1:0]    found_r;
  logic [PW-1:0]    ptr_r, hi_r;
  logic [1:0]       ph_r;
  logic [HW:0]      ek_r, emit_r;
  logic [WGT_W-1:0] w_r;
  logic             trunc_r;
  logic             ovalid_r;
  logic [GLB_W-1:0] orow_r, ocol_r;
  logic [WGT_W-1:0] ow_r;
  logic             ohas_r, olast_r, otr_r;

  logic [VAL_W-1:0] rs_q;
  logic [IDX_W:0]   co_q;
  logic             vis_q;
  logic [VAL_W-1:0] nb_q;
  logic [NW-1:0]    fr_q, fl_q;
  logic             div_done;
  logic [WGT_W-1:0] div_q;
  logic             div_start;
  logic             acc;
  logic [VAL_W-1:0] lo_r;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || ovalid_r;

  // memory addresses
  logic [RW-1:0] rs_ra;
  logic [EW-1:0] nb_ra;
  logic [NW-1:0] co_ra, vis_ra, fr_ra;
  logic [HW-1:0] fl_ra;

  always_comb begin
    rs_ra  = RW'(node_r);
    if (state_r == S_NBRD && ph_r == 2'd2) rs_ra = RW'(node_r) + RW'(1);
    nb_ra  = EW'(ptr_r);
    co_ra  = (state_r == S_IDLE) ? NW'(in_value) : node_r;
    if (state_r == S_EMIT) co_ra = fl_q;
    vis_ra = NW'(nb_q);
    fr_ra  = NW'(fi_r);
    fl_ra  = HW'(ek_r);
  end

  always_ff @(posedge clk) begin
    rs_q  <= rs_mem[rs_ra];
    nb_q  <= nb_mem[nb_ra];
    co_q  <= co_mem[co_ra];
    vis_q <= vis_mem[vis_ra];
    fr_q  <= fr_mem[fsel_r][fr_ra];
    fl_q  <= fl_mem[fl_ra];
  end

  // writes
  logic nb_ok;
  assign nb_ok = (32'(nb_q) < MAX_NODES) && (nb_q != VAL_W'(node_r)) && !vis_q;

  always_ff @(posedge clk) begin
    if (acc && in_op == OP_ROW_START && 32'(in_index) <= MAX_NODES)
      rs_mem[RW'(in_index)] <= in_value;
    if (acc && in_op == OP_COL_ENTRY && 32'(in_index) < MAX_EDGES)
      nb_mem[EW'(in_index)] <= in_value;
    if (state_r == S_CLEAR)
      co_mem[clr_r] <= '0;
    else if (acc && in_op == OP_MARK && 32'(in_value) < MAX_NODES)
      co_mem[NW'(in_value)] <= {1'b1, in_index};
    if (state_r == S_VCLR)
      vis_mem[clr_r] <= (clr_r == NW'(val_r));
    else if (state_r == S_NBCHK && ph_r == 2'd0 && nb_ok)
      vis_mem[NW'(nb_q)] <= 1'b1;
    if (state_r == S_VCLR && clr_r == '0)
      fr_mem[1'b0][0] <= NW'(val_r);
    else if (state_r == S_NBCHK && ph_r == 2'd0 && nb_ok)
      fr_mem[!fsel_r][NW'(nnext_r)] <= NW'(nb_q);
    if (state_r == S_QCHK && co_q[IDX_W] && found_r < CW'(MAX_HITS) && ph_r == 2'd1)
      fl_mem[HW'(found_r)] <= node_r;
  end

  nciw_recip #(.CNT_W(CW)) u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .count    (found_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign div_start = (state_r == S_LVL) && !(found_r < CW'(2) && ncur_r != '0) && found_r != '0;

  // Control. S_QCHK (ph 1) scans the frontier for coarse nodes, (ph 0) queries start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      ovalid_r  <= 1'b0;
      row_ofs_r <= '0;
      col_ofs_r <= '0;
      ph_r      <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_ROW_OFFSET) row_ofs_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_COL_OFFSET) col_ofs_r <= cfg_data;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == NW'(MAX_NODES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (acc) begin
            op_r  <= in_op;
            val_r <= in_value;
            node_r <= NW'(in_value);
            state_r <= S_QRD;
          end
        end
        S_QRD: begin
          orow_r <= GLB_W'(val_r) + GLB_W'(row_ofs_r);
          ocol_r <= '0; ow_r <= '0; ohas_r <= 1'b0; olast_r <= 1'b1; otr_r <= 1'b0;
          if (op_r != OP_QUERY) begin
            orow_r <= '0;
            state_r <= S_OUT;
          end else if (32'(val_r) >= MAX_NODES) begin
            state_r <= S_OUT;
          end else begin
            ph_r <= 2'd0;
            state_r <= S_QCHK;
          end
        end
        S_QCHK: begin
          if (ph_r == 2'd0) begin
            if (co_q[IDX_W]) begin
              ocol_r <= GLB_W'(co_q[IDX_W-1:0]) + GLB_W'(col_ofs_r);
              ow_r   <= WEIGHT_ONE;
              ohas_r <= 1'b1;
              state_r <= S_OUT;
            end else begin
              clr_r   <= '0;
              state_r <= S_VCLR;
            end
          end else begin
            if (co_q[IDX_W]) found_r <= found_r + 1'b1;
            state_r <= S_NODE;
          end
        end
        S_VCLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == NW'(MAX_NODES - 1)) begin
            fsel_r  <= 1'b0;
            ncur_r  <= FW'(1);
            found_r <= '0;
            fi_r    <= '0;
            ph_r    <= 2'd1;
            state_r <= S_LVL;
          end
        end
        S_LVL: begin
          // level start: test stop rule, then pass A (coarse scan)
          fi_r    <= '0;
          nnext_r <= '0;
          if (found_r < CW'(2) && ncur_r != '0) begin
            ph_r    <= 2'd3;
            state_r <= S_NODE;
          end else if (found_r == '0) begin
            state_r <= S_OUT;
          end else begin
            emit_r  <= (found_r < CW'(MAX_HITS)) ? (HW+1)'(found_r) : (HW+1)'(MAX_HITS);
            trunc_r <= found_r > CW'(MAX_HITS);
            state_r <= S_DIV;
          end
        end
        S_NODE: begin
          // ph 3: fetch frontier entry for coarse scan; ph 1 after check: next
          // ph 2: fetch frontier entry for edge pass
          if (ph_r == 2'd3) begin
            if (fi_r == ncur_r) begin
              fi_r <= '0;
              ph_r <= 2'd2;
            end else begin
              ph_r <= 2'd0;
              state_r <= S_RS;
            end
          end else if (ph_r == 2'd1) begin
            fi_r <= fi_r + 1'b1;
            ph_r <= 2'd3;
          end else begin
            if (fi_r == ncur_r) begin
              fsel_r  <= !fsel_r;
              ncur_r  <= nnext_r;
              state_r <= S_LVL;
            end else begin
              ph_r    <= 2'd2;
              state_r <= S_RS;
            end
          end
        end
        S_RS: begin
          // fr_q valid now; ph 0: coarse scan, ph 2: edges
          node_r <= fr_q;
          if (ph_r == 2'd0) begin
            ph_r    <= 2'd1;
            state_r <= S_NBRD;
          end else begin
            ph_r    <= 2'd3;
            state_r <= S_NBRD;
          end
        end
        S_NBRD: begin
          // node_r settled: co_q / rs reads land next cycle
          if (ph_r == 2'd1) begin
            state_r <= S_QCHK;
          end else if (ph_r == 2'd3) begin
            // row start read issued, row end read follows
            ph_r <= 2'd2;
          end else if (ph_r == 2'd2) begin
            lo_r <= rs_q;
            ph_r <= 2'd0;
          end else begin
            // rs_q now holds row end
            hi_r  <= (PW'(rs_q) < PW'(MAX_EDGES)) ? PW'(rs_q) : PW'(MAX_EDGES);
            ptr_r <= PW'(lo_r);
            ph_r  <= 2'd1;
            state_r <= S_NBCHK;
          end
        end
        S_NBCHK: begin
          // ph 1: issue read at ptr; ph 3: nb_q ready, issue visited read; ph 0: decide
          if (ph_r == 2'd1) begin
            if (ptr_r >= hi_r) begin
              fi_r    <= fi_r + 1'b1;
              ph_r    <= 2'd2;
              state_r <= S_NODE;
            end else begin
              ph_r <= 2'd3;
            end
          end else if (ph_r == 2'd3) begin
            ph_r <= 2'd0;
          end else begin
            if (nb_ok) nnext_r <= nnext_r + 1'b1;
            ptr_r <= ptr_r + 1'b1;
            ph_r  <= 2'd1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            w_r  <= div_q;
            ek_r <= '0;
            ph_r <= 2'd0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // ph 0: fl read issued; ph 1: co read issued; ph 2: co_q ready
          if (ph_r == 2'd2) begin
            ocol_r  <= GLB_W'(co_q[IDX_W-1:0]) + GLB_W'(col_ofs_r);
            ow_r    <= w_r;
            ohas_r  <= 1'b1;
            otr_r   <= trunc_r;
            olast_r <= (ek_r + 1'b1 == emit_r);
            ovalid_r <= 1'b1;
            ek_r    <= ek_r + 1'b1;
            ph_r    <= 2'd0;
            state_r <= S_EMWAIT;
          end else begin
            ph_r <= ph_r + 1'b1;
          end
        end
        S_EMWAIT: begin
          if (!ovalid_r || !out_stall) begin
            if (ek_r == emit_r) state_r <= S_IDLE;
            else state_r <= S_EMIT;
          end
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // visited read at nb_q: ph 3 issues it (nb_q valid), so vis_q valid at ph 0.
  // A write at ph 0 of the previous neighbor lands before ph 1, ahead of that read: no overlap.

  assign out_valid     = ovalid_r;
  assign out_row_index = orow_r;
  assign out_col_index = ocol_r;
  assign out_weight    = ow_r;
  assign out_has_entry = ohas_r;
  assign out_last      = olast_r;
  assign out_truncated = otr_r;

endmodule

@@ hw/rtl/nciw_checker.sv @@
module nciw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_has_entry,
  input logic out_last,
  input logic out_truncated,
  input logic [16:0] out_weight
);
  import nciw_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_weight))
    else $error("stalled result beat changed");

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result waits");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_entry |-> out_last && !out_truncated && out_weight == '0)
    else $error("empty beat not final");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_weight <= WEIGHT_ONE)
    else $error("weight above one");
endmodule

bind nearest_coarse_interpolation_weights nciw_checker u_nciw_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_has_entry(out_has_entry),
  .out_last(out_last), .out_truncated(out_truncated), .out_weight(out_weight)
);
